/* hdl/msp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package msp_pkg;

    localparam int NUM_STACKS = 4;
    localparam int NUM_SLOTS  = 16;

    // Slot pointer carries one extra code: NUM_SLOTS means null.
    localparam int PTR_W   = $clog2(NUM_SLOTS + 1);
    localparam int IDX_W   = $clog2(NUM_SLOTS);
    localparam int SID_W   = 2;
    localparam int DATA_W  = 32;
    localparam int STAT_W  = 2;

    localparam logic MODE_PUSH = 1'b0;
    localparam logic MODE_POP  = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_DONE        = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_POOL_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_STACK_EMPTY = 2'd2;

    localparam logic [PTR_W-1:0] PTR_NULL = PTR_W'(NUM_SLOTS);

    typedef enum logic
    {
        ST_IDLE,
        ST_EXEC
    } state_t;

    typedef logic [PTR_W-1:0] ptr_t;

    // Any code at or past NUM_SLOTS counts as null.
    function automatic logic ptr_is_null(input ptr_t p);
        return p >= PTR_NULL;
    endfunction

    // Link of a slot never written since reset: the next slot, last one null.
    function automatic ptr_t link_init(input logic [IDX_W-1:0] idx);
        return PTR_W'(idx) + PTR_W'(1);
    endfunction

endpackage

`default_nettype wire

/* hdl/msp_link_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module msp_link_mem
(
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         rd_en,
    input  wire  [msp_pkg::IDX_W-1:0]   rd_addr,
    output msp_pkg::ptr_t               rd_data,
    input  wire                         wr_en,
    input  wire  [msp_pkg::IDX_W-1:0]   wr_addr,
    input  wire  msp_pkg::ptr_t         wr_data
);

    msp_pkg::ptr_t                   link_mem [msp_pkg::NUM_SLOTS];
    logic [msp_pkg::NUM_SLOTS-1:0]   written_reg;
    msp_pkg::ptr_t                   rd_mem_reg;
    logic                            rd_written_reg;
    logic [msp_pkg::IDX_W-1:0]       rd_addr_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            link_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_mem_reg  <= link_mem[rd_addr];
            rd_addr_reg <= rd_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg    <= '0;
            rd_written_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                written_reg[wr_addr] <= 1'b1;
            end
            if (rd_en)
            begin
                rd_written_reg <= written_reg[rd_addr];
            end
        end
    end

    assign rd_data = rd_written_reg ? rd_mem_reg : msp_pkg::link_init(rd_addr_reg);

endmodule

`default_nettype wire

/* hdl/msp_data_mem.sv */
`timescale 1ns / 1ps
`default_nettype none

module msp_data_mem
(
    input  wire                         clk,
    input  wire                         rd_en,
    input  wire  [msp_pkg::IDX_W-1:0]   rd_addr,
    output logic [msp_pkg::DATA_W-1:0]  rd_data,
    input  wire                         wr_en,
    input  wire  [msp_pkg::IDX_W-1:0]   wr_addr,
    input  wire  [msp_pkg::DATA_W-1:0]  wr_data
);

    logic [msp_pkg::DATA_W-1:0] data_mem [msp_pkg::NUM_SLOTS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            data_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= data_mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* hdl/multi_stack_shared_pool_unit.sv */
`timescale 1ns / 1ps
`default_nettype none

// Four LIFO stacks sharing a pool of 16 slots, chained through a link memory.
// Input channel (in_valid/in_ready): one beat is a push of push_value or a pop
// from stack stack_id, chosen by mode. Output channel (out_valid/out_ready):
// exactly one result beat per input beat, in order, carrying pop_value,
// status, stack_now_empty and pool_now_full.
// Each beat is accepted in ST_IDLE, whose accept edge reads the selected slot's
// link and data; the write-back step in ST_EXEC then writes the links back and
// loads the result register. A new beat is accepted only after the previous
// beat has left its write-back step.
// A result waiting in the output register does not block the next input
// beat; only if the receiver still stalls when that beat's result is ready
// does the block hold in its write-back step until the register drains.
// Reset: all stacks empty, every slot free in ascending order, output empty.
// Slot links reset through per-slot written flags, so no clearing pass runs.

module multi_stack_shared_pool_unit
(
    input  wire                           clk,
    input  wire                           rst_n,
    input  wire                           in_valid,
    output logic                          in_ready,
    input  wire                           mode,
    input  wire  [msp_pkg::SID_W-1:0]     stack_id,
    input  wire  signed [msp_pkg::DATA_W-1:0] push_value,
    output logic                          out_valid,
    input  wire                           out_ready,
    output logic signed [msp_pkg::DATA_W-1:0] pop_value,
    output logic [msp_pkg::STAT_W-1:0]    status,
    output logic                          stack_now_empty,
    output logic                          pool_now_full
);

    msp_pkg::state_t state_reg;
    msp_pkg::state_t state_next;

    msp_pkg::ptr_t                  top_reg [msp_pkg::NUM_STACKS];
    msp_pkg::ptr_t                  free_head_reg;

    logic                           mode_reg;
    logic [msp_pkg::SID_W-1:0]      sid_reg;
    logic [msp_pkg::DATA_W-1:0]     value_reg;
    msp_pkg::ptr_t                  slot_reg;
    logic                           fail_reg;

    logic                           out_valid_reg;
    logic [msp_pkg::DATA_W-1:0]     pop_value_reg;
    logic [msp_pkg::STAT_W-1:0]     status_reg;
    logic                           empty_reg;
    logic                           full_reg;

    logic                           in_fire;
    logic                           out_free;
    logic                           exec_fire;
    msp_pkg::ptr_t                  sel_slot;
    logic                           sel_null;

    msp_pkg::ptr_t                  link_rd;
    logic [msp_pkg::DATA_W-1:0]     data_rd;
    logic                           link_wr_en;
    msp_pkg::ptr_t                  link_wr_data;
    logic                           data_wr_en;

    msp_pkg::ptr_t                  top_cur;
    msp_pkg::ptr_t                  new_top;
    msp_pkg::ptr_t                  new_free;
    logic [msp_pkg::DATA_W-1:0]     res_value;
    logic [msp_pkg::STAT_W-1:0]     res_status;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_fire   = in_valid && in_ready;
    assign sel_slot  = (mode == msp_pkg::MODE_POP) ? top_reg[stack_id] : free_head_reg;
    assign sel_null  = msp_pkg::ptr_is_null(sel_slot);
    assign top_cur   = top_reg[sid_reg];

    msp_link_mem u_link_mem
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (in_fire && !sel_null),
        .rd_addr (sel_slot[msp_pkg::IDX_W-1:0]),
        .rd_data (link_rd),
        .wr_en   (link_wr_en),
        .wr_addr (slot_reg[msp_pkg::IDX_W-1:0]),
        .wr_data (link_wr_data)
    );

    msp_data_mem u_data_mem
    (
        .clk     (clk),
        .rd_en   (in_fire && !sel_null),
        .rd_addr (sel_slot[msp_pkg::IDX_W-1:0]),
        .rd_data (data_rd),
        .wr_en   (data_wr_en),
        .wr_addr (slot_reg[msp_pkg::IDX_W-1:0]),
        .wr_data (value_reg)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= msp_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state, write-back and result values
    always_comb
    begin
        state_next   = state_reg;
        in_ready     = 1'b0;
        exec_fire    = 1'b0;
        link_wr_en   = 1'b0;
        data_wr_en   = 1'b0;
        link_wr_data = top_cur;
        new_top      = top_cur;
        new_free     = free_head_reg;
        res_value    = '0;
        res_status   = msp_pkg::STATUS_DONE;
        case (state_reg)
            msp_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    state_next = msp_pkg::ST_EXEC;
                end
            end
            msp_pkg::ST_EXEC:
            begin
                if (out_free)
                begin
                    exec_fire  = 1'b1;
                    state_next = msp_pkg::ST_IDLE;
                end
                if (fail_reg)
                begin
                    res_status = (mode_reg == msp_pkg::MODE_POP) ?
                                 msp_pkg::STATUS_STACK_EMPTY : msp_pkg::STATUS_POOL_FULL;
                end
                else if (mode_reg == msp_pkg::MODE_PUSH)
                begin
                    link_wr_en   = exec_fire;
                    data_wr_en   = exec_fire;
                    link_wr_data = top_cur;
                    new_free     = link_rd;
                    new_top      = slot_reg;
                end
                else
                begin
                    link_wr_en   = exec_fire;
                    link_wr_data = free_head_reg;
                    new_top      = link_rd;
                    new_free     = slot_reg;
                    res_value    = data_rd;
                end
            end
            default:
            begin
                state_next = msp_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            mode_reg  <= mode;
            sid_reg   <= stack_id;
            value_reg <= push_value;
            slot_reg  <= sel_slot;
            fail_reg  <= sel_null;
        end
        if (exec_fire)
        begin
            pop_value_reg <= res_value;
            status_reg    <= res_status;
            empty_reg     <= msp_pkg::ptr_is_null(new_top);
            full_reg      <= msp_pkg::ptr_is_null(new_free);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < msp_pkg::NUM_STACKS; i++)
            begin
                top_reg[i] <= msp_pkg::PTR_NULL;
            end
            free_head_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (exec_fire)
            begin
                top_reg[sid_reg] <= new_top;
                free_head_reg    <= new_free;
                out_valid_reg    <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid       = out_valid_reg;
    assign pop_value       = pop_value_reg;
    assign status          = status_reg;
    assign stack_now_empty = empty_reg;
    assign pool_now_full   = full_reg;

endmodule

`default_nettype wire

/* dv/multi_stack_shared_pool_unit_tb.sv */
`timescale 1ns / 1ps

module multi_stack_shared_pool_unit_tb;

    localparam int CLK_PERIOD   = 8;
    localparam int RANDOM_BEATS = 1625;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 10;

    typedef struct packed
    {
        logic signed [msp_pkg::DATA_W-1:0] pop_value;
        logic [msp_pkg::STAT_W-1:0]        status;
        logic                              stack_empty;
        logic                              pool_full;
    } stack_result_t;

    // Shadow of the stacks and free list; one expected result per accepted beat.
    class stack_pool_scoreboard;
        logic [msp_pkg::DATA_W-1:0] slot_data [msp_pkg::NUM_SLOTS];
        msp_pkg::ptr_t              slot_link [msp_pkg::NUM_SLOTS];
        msp_pkg::ptr_t              stack_top [msp_pkg::NUM_STACKS];
        msp_pkg::ptr_t              free_head;
        stack_result_t              expected_q [$];
        int                         errors;
        int                         n_push;
        int                         n_pop;
        int                         n_full;
        int                         n_empty;
        int                         n_checked;

        function new();
            for (int i = 0; i < msp_pkg::NUM_SLOTS; i++)
            begin
                slot_data[i] = '0;
                slot_link[i] = msp_pkg::ptr_t'(i + 1);
            end
            for (int i = 0; i < msp_pkg::NUM_STACKS; i++)
                stack_top[i] = msp_pkg::ptr_t'(msp_pkg::NUM_SLOTS);
            free_head = '0;
            errors    = 0;
            n_push    = 0;
            n_pop     = 0;
            n_full    = 0;
            n_empty   = 0;
            n_checked = 0;
        endfunction

        function bit no_slot(msp_pkg::ptr_t p);
            return int'(p) >= msp_pkg::NUM_SLOTS;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void note_beat(logic op, logic [msp_pkg::SID_W-1:0] sid,
                                logic [msp_pkg::DATA_W-1:0] value);
            stack_result_t               r;
            msp_pkg::ptr_t               slot;
            logic [msp_pkg::IDX_W-1:0]   idx;
            logic [msp_pkg::SID_W-1:0]   s;
            s = msp_pkg::SID_W'(int'(sid) % msp_pkg::NUM_STACKS);
            r = '0;
            r.status = msp_pkg::STATUS_DONE;
            if (op == msp_pkg::MODE_PUSH)
            begin
                n_push++;
                if (no_slot(free_head))
                begin
                    r.status = msp_pkg::STATUS_POOL_FULL;
                    n_full++;
                end
                else
                begin
                    slot           = free_head;
                    idx            = slot[msp_pkg::IDX_W-1:0];
                    free_head      = slot_link[idx];
                    slot_link[idx] = stack_top[s];
                    stack_top[s]   = slot;
                    slot_data[idx] = value;
                end
            end
            else
            begin
                n_pop++;
                if (no_slot(stack_top[s]))
                begin
                    r.status = msp_pkg::STATUS_STACK_EMPTY;
                    n_empty++;
                end
                else
                begin
                    slot           = stack_top[s];
                    idx            = slot[msp_pkg::IDX_W-1:0];
                    stack_top[s]   = slot_link[idx];
                    slot_link[idx] = free_head;
                    free_head      = slot;
                    r.pop_value    = slot_data[idx];
                end
            end
            r.stack_empty = no_slot(stack_top[s]);
            r.pool_full   = no_slot(free_head);
            expected_q.push_back(r);
        endfunction

        task report(string what);
            errors++;
            $display("[%0t] MISMATCH %s", $time, what);
        endtask

        task check_result(logic signed [msp_pkg::DATA_W-1:0] value,
                          logic [msp_pkg::STAT_W-1:0] st,
                          logic stack_empty, logic pool_full);
            stack_result_t e;
            if (expected_q.size() == 0)
            begin
                report($sformatf("unexpected result beat value=%0d status=%0d",
                                 value, st));
                return;
            end
            e = expected_q.pop_front();
            n_checked++;
            if (value !== e.pop_value)
                report($sformatf("beat %0d pop_value got %0d want %0d",
                                 n_checked, value, e.pop_value));
            if (st !== e.status)
                report($sformatf("beat %0d status got %0d want %0d",
                                 n_checked, st, e.status));
            if (stack_empty !== e.stack_empty)
                report($sformatf("beat %0d stack_now_empty got %b want %b",
                                 n_checked, stack_empty, e.stack_empty));
            if (pool_full !== e.pool_full)
                report($sformatf("beat %0d pool_now_full got %b want %b",
                                 n_checked, pool_full, e.pool_full));
        endtask
    endclass

    logic                              clk        = 1'b0;
    logic                              rst_n      = 1'b0;
    logic                              in_valid   = 1'b0;
    logic                              in_ready;
    logic                              mode       = msp_pkg::MODE_PUSH;
    logic [msp_pkg::SID_W-1:0]         stack_id   = '0;
    logic signed [msp_pkg::DATA_W-1:0] push_value = '0;
    logic                              out_valid;
    logic                              out_ready  = 1'b0;
    logic signed [msp_pkg::DATA_W-1:0] pop_value;
    logic [msp_pkg::STAT_W-1:0]        status;
    logic                              stack_now_empty;
    logic                              pool_now_full;

    bit steady   = 1'b0;
    bit hold_req = 1'b0;
    int cycles   = 0;

    stack_pool_scoreboard sb = new();

    multi_stack_shared_pool_unit dut
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .mode            (mode),
        .stack_id        (stack_id),
        .push_value      (push_value),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .pop_value       (pop_value),
        .status          (status),
        .stack_now_empty (stack_now_empty),
        .pool_now_full   (pool_now_full)
    );

    initial
    begin
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycles, sb.pending());
            $display("multi_stack_shared_pool_unit test failed");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            sb.check_result(pop_value, status, stack_now_empty, pool_now_full);
    end

    // Receiver: random back-pressure, none in the steady window, one long hold.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_req = 1'b0;
            end
            else
                out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 30);
        end
    end

    task automatic send_beat(logic op, logic [msp_pkg::SID_W-1:0] sid,
                             logic [msp_pkg::DATA_W-1:0] value);
        @(negedge clk);
        if (!steady && $urandom_range(0, 99) < 30)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        in_valid   <= 1'b1;
        mode       <= op;
        stack_id   <= sid;
        push_value <= value;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        sb.note_beat(op, sid, value);
    endtask

    task automatic pause_until_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [msp_pkg::DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return 32'h0000_0000;
            3: return 32'hffff_ffff;
            default: return $urandom;
        endcase
    endfunction

    task automatic run_directed();
        logic [msp_pkg::DATA_W-1:0] edge_vals [6];
        edge_vals = '{32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000,
                      32'hffff_ffff, 32'haaaa_aaaa, 32'h5555_5555};
        // pops on empty stacks first
        send_beat(msp_pkg::MODE_POP, 2'd0, 32'h1234_5678);
        send_beat(msp_pkg::MODE_POP, 2'd3, 32'hffff_ffff);
        // fill every slot, spread over all stacks
        for (int i = 0; i < msp_pkg::NUM_SLOTS; i++)
            send_beat(msp_pkg::MODE_PUSH, msp_pkg::SID_W'(i % msp_pkg::NUM_STACKS),
                      (i < 6) ? edge_vals[i] : $urandom);
        // pool exhausted
        send_beat(msp_pkg::MODE_PUSH, 2'd2, 32'hdead_beef);
        send_beat(msp_pkg::MODE_POP, 2'd0, '0);
        send_beat(msp_pkg::MODE_POP, 2'd1, '0);
        send_beat(msp_pkg::MODE_POP, 2'd2, '0);
        send_beat(msp_pkg::MODE_POP, 2'd3, '0);
        send_beat(msp_pkg::MODE_POP, 2'd3, '0);
        send_beat(msp_pkg::MODE_POP, 2'd2, '0);
    endtask

    // Phases lean towards pushes or pops so the pool runs full and stacks drain.
    task automatic run_random();
        int push_pct;
        push_pct = 50;
        for (int n = 0; n < RANDOM_BEATS; n++)
        begin
            if (n % 40 == 0)
            begin
                case ($urandom_range(0, 2))
                    0: push_pct = 15;
                    1: push_pct = 50;
                    default: push_pct = 85;
                endcase
            end
            if (n == 400)
                hold_req = 1'b1;
            if (n == 600)
                steady = 1'b1;
            if (n == 900)
                steady = 1'b0;
            if (n == 1000)
                pause_until_drained();
            send_beat(($urandom_range(0, 99) < push_pct) ?
                          msp_pkg::MODE_PUSH : msp_pkg::MODE_POP,
                      msp_pkg::SID_W'($urandom_range(0, msp_pkg::NUM_STACKS - 1)),
                      pick_value());
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        run_directed();
        run_random();
        @(negedge clk);
        in_valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));

        $display("covered %0d pushes (%0d refused, pool full) and %0d pops (%0d refused, empty)",
                 sb.n_push, sb.n_full, sb.n_pop, sb.n_empty);
        $display("%0d result beats checked, %0d mismatches", sb.n_checked, sb.errors);
        if (sb.errors == 0)
            $display("multi_stack_shared_pool_unit test passed");
        else
            $display("multi_stack_shared_pool_unit test failed");
        $finish;
    end

endmodule
